/* design/anim_descriptor_layout_walker_unit_assert.svh */
// assertion macros used by the descriptor walker top level
`ifndef ANIM_DESCRIPTOR_LAYOUT_WALKER_UNIT_ASSERT_SVH
`define ANIM_DESCRIPTOR_LAYOUT_WALKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ADLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ADLW_ASSERT(lbl, prop, msg)
`define ADLW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/adlw_pkg.sv */
// types, constants and helper functions of the descriptor walker
package adlw_pkg;

  localparam logic [15:0] MAX_HEADER_BYTES  = 16'hFFFF;
  localparam logic [15:0] MAX_PAYLOAD_BYTES = 16'hFFFF;

  // flag bit positions
  localparam int FL_S16_ROT = 0;
  localparam int FL_S16_TRN = 1;
  localparam int FL_TRN08   = 2;
  localparam int FL_F32_ROT = 3;
  localparam int FL_S32_TRN = 4;
  localparam int FL_CAMERA  = 5;
  localparam int FL_F32_SCL = 6;
  localparam int FL_UNKNOWN = 7;

  localparam logic [4:0] LEN_TRN08 = 5'd12;
  localparam logic [4:0] LEN_S16   = 5'd9;
  localparam logic [4:0] LEN_S32   = 5'd15;
  localparam logic [4:0] LEN_CAM   = 5'd5;
  localparam logic [8:0] F32_SPAN  = 9'd96;
  localparam logic [7:0] LIM_32    = 8'd32;
  localparam logic [7:0] LIM_16    = 8'd16;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_FLAGS = 3'd1;
  localparam logic [2:0] ST_HDR_TRUNC = 3'd2;
  localparam logic [2:0] ST_WIDTH_BAD = 3'd3;
  localparam logic [2:0] ST_PAY_TRUNC = 3'd4;
  localparam logic [2:0] ST_TRAILING  = 3'd5;

  // register indexes
  localparam logic [1:0] REG_WALK_MODE  = 2'd0;
  localparam logic [1:0] REG_FRAME_LEN  = 2'd1;
  localparam logic [1:0] REG_PART_COUNT = 2'd2;
  localparam logic [1:0] REG_TARGET     = 2'd3;

  typedef struct packed {
    logic        walk_mode;
    logic [15:0] frame_byte_len;
    logic [15:0] part_count;
    logic [15:0] target_part;
  } cfg_t;

  typedef struct packed {
    logic        awaiting_flags;
    logic [7:0]  part_flag_bits;
    logic [4:0]  part_byte_pos;
    logic [4:0]  part_bytes_needed;
    logic [8:0]  part_bit_sum;
    logic        width_fault;
    logic [18:0] running_bit_offset;
    logic [15:0] bytes_consumed;
    logic [15:0] parts_done;
    logic        stream_finished;
  } walk_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] hdr_offset;
    logic [18:0] bit_offset;
    logic [18:0] bit_count;
    logic [7:0]  part_flags;
  } result_t;

  localparam walk_state_t WALK_RESET = '{
    awaiting_flags:     1'b1,
    part_flag_bits:     8'd0,
    part_byte_pos:      5'd0,
    part_bytes_needed:  5'd0,
    part_bit_sum:       9'd0,
    width_fault:        1'b0,
    running_bit_offset: 19'd0,
    bytes_consumed:     16'd0,
    parts_done:         16'd0,
    stream_finished:    1'b0
  };

  function automatic logic [4:0] translate_len(input logic [7:0] f);
    logic [4:0] len;
    if (f[FL_TRN08]) len = LEN_TRN08;
    else if (f[FL_S16_TRN]) len = LEN_S16;
    else if (f[FL_S32_TRN]) len = LEN_S32;
    else len = 5'd0;
    return len;
  endfunction

  // limit of the width byte at field position pos, zero where no width byte sits
  function automatic logic [7:0] width_limit(input logic [7:0] f, input logic [4:0] pos);
    logic [4:0] t;
    logic [4:0] p;
    logic [7:0] lim;
    t   = translate_len(f);
    p   = pos - t;
    lim = 8'd0;
    if (pos < t) begin
      if (f[FL_S32_TRN]) begin
        if (pos == 5'd0 || pos == 5'd5 || pos == 5'd10) lim = LIM_32;
      end else if (pos == 5'd2 || pos == 5'd5 || pos == 5'd8 || pos == 5'd11) begin
        lim = f[FL_TRN08] ? LIM_32 : LIM_16;
      end
    end else if (f[FL_S16_ROT] && p < LEN_S16) begin
      if (p == 5'd2 || p == 5'd5 || p == 5'd8) lim = LIM_16;
    end else begin
      if (f[FL_S16_ROT]) p = p - LEN_S16;
      if (f[FL_CAMERA] && p == 5'd0) lim = LIM_32;
    end
    return lim;
  endfunction

endpackage

/* design/adlw_if.sv */
// handshake channels for header bytes and walk results
interface adlw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       last_byte;

  modport source (output valid, output header_byte, output last_byte, input ready);
  modport sink (input valid, input header_byte, input last_byte, output ready);
endinterface

interface adlw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] hdr_offset;
  logic [18:0] bit_offset;
  logic [18:0] bit_count;
  logic [7:0]  part_flags;

  modport source (output valid, output status, output hdr_offset, output bit_offset,
                  output bit_count, output part_flags, input ready);
  modport sink (input valid, input status, input hdr_offset, input bit_offset,
                input bit_count, input part_flags, output ready);
endinterface

/* design/adlw_cfg.sv */
// configuration register file behind the apb port
module adlw_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output adlw_pkg::cfg_t      cfg
);
  import adlw_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.walk_mode      <= 1'b0;
      cfg_r.frame_byte_len <= 16'd0;
      cfg_r.part_count     <= 16'd1;
      cfg_r.target_part    <= 16'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WALK_MODE:  cfg_r.walk_mode      <= pwdata[0];
        REG_FRAME_LEN:  cfg_r.frame_byte_len <= pwdata[15:0];
        REG_PART_COUNT: cfg_r.part_count     <= pwdata[15:0];
        REG_TARGET:     cfg_r.target_part    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WALK_MODE:  prdata = {31'd0, cfg_r.walk_mode};
      REG_FRAME_LEN:  prdata = {16'd0, cfg_r.frame_byte_len};
      REG_PART_COUNT: prdata = {16'd0, cfg_r.part_count};
      REG_TARGET:     prdata = {16'd0, cfg_r.target_part};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* design/adlw_step.sv */
// next-state and result logic for one header byte
module adlw_step (
  input  adlw_pkg::walk_state_t st,
  input  adlw_pkg::cfg_t        cfg,
  input  logic [7:0]            hdr_byte,
  input  logic                  last,
  output adlw_pkg::walk_state_t st_nxt,
  output logic                  res_vld,
  output adlw_pkg::result_t     res
);
  import adlw_pkg::*;

  logic        flags_bad;
  logic [4:0]  flags_need;
  logic [8:0]  flags_sum;
  logic [7:0]  lim;
  logic        fld_hit;
  logic [8:0]  sum_fld;
  logic        fault_fld;
  logic [4:0]  pos_inc;
  logic [15:0] cons_inc;
  logic [15:0] parts_inc;
  logic [8:0]  c_sum;
  logic        c_fault;
  logic [4:0]  c_needed;
  logic [7:0]  c_flags;
  logic [15:0] cap_bytes;
  logic [18:0] cap;
  logic [19:0] run_tot;
  logic        part_done;

  assign flags_bad = hdr_byte[FL_UNKNOWN]
                   | (hdr_byte[FL_TRN08] & hdr_byte[FL_S16_TRN])
                   | (hdr_byte[FL_TRN08] & hdr_byte[FL_S32_TRN])
                   | (hdr_byte[FL_S16_TRN] & hdr_byte[FL_S32_TRN])
                   | (hdr_byte[FL_S16_ROT] & hdr_byte[FL_F32_ROT]);

  assign flags_need = translate_len(hdr_byte)
                    + (hdr_byte[FL_S16_ROT] ? LEN_S16 : 5'd0)
                    + (hdr_byte[FL_CAMERA] ? LEN_CAM : 5'd0);
  assign flags_sum  = (hdr_byte[FL_F32_ROT] ? F32_SPAN : 9'd0)
                    + (hdr_byte[FL_F32_SCL] ? F32_SPAN : 9'd0);

  assign lim       = width_limit(st.part_flag_bits, st.part_byte_pos);
  assign fld_hit   = (lim != 8'd0);
  assign sum_fld   = st.part_bit_sum + ((fld_hit && hdr_byte <= lim) ? {1'b0, hdr_byte} : 9'd0);
  assign fault_fld = st.width_fault | (fld_hit && hdr_byte > lim);
  assign pos_inc   = st.part_byte_pos + 5'd1;
  assign cons_inc  = st.bytes_consumed + 16'd1;
  assign parts_inc = (st.parts_done != 16'hFFFF) ? st.parts_done + 16'd1 : st.parts_done;

  // a part with no field bytes completes on its flags byte
  assign c_sum    = st.awaiting_flags ? flags_sum  : sum_fld;
  assign c_fault  = st.awaiting_flags ? 1'b0       : fault_fld;
  assign c_needed = st.awaiting_flags ? flags_need : st.part_bytes_needed;
  assign c_flags  = st.awaiting_flags ? hdr_byte   : st.part_flag_bits;

  assign cap_bytes = (cfg.frame_byte_len > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES
                                                               : cfg.frame_byte_len;
  assign cap       = {cap_bytes, 3'b000};
  assign run_tot   = {1'b0, st.running_bit_offset} + {11'd0, c_sum};

  always_comb begin
    st_nxt    = st;
    res_vld   = 1'b0;
    res       = '0;
    part_done = 1'b0;

    if (st.stream_finished) begin
      if (last) st_nxt = WALK_RESET;
    end else if (st.bytes_consumed >= MAX_HEADER_BYTES) begin
      res_vld    = 1'b1;
      res.status = ST_HDR_TRUNC;
    end else begin
      st_nxt.bytes_consumed = cons_inc;
      if (st.awaiting_flags) begin
        priority if (!cfg.walk_mode && st.parts_done >= cfg.part_count) begin
          res_vld    = 1'b1;
          res.status = ST_TRAILING;
        end else if (flags_bad) begin
          res_vld    = 1'b1;
          res.status = ST_BAD_FLAGS;
        end else begin
          st_nxt.part_flag_bits    = hdr_byte;
          st_nxt.part_byte_pos     = 5'd0;
          st_nxt.part_bytes_needed = flags_need;
          st_nxt.part_bit_sum      = flags_sum;
          st_nxt.width_fault       = 1'b0;
          st_nxt.awaiting_flags    = 1'b0;
          if (flags_need == 5'd0) begin
            part_done = 1'b1;
          end else if (last) begin
            res_vld    = 1'b1;
            res.status = ST_HDR_TRUNC;
          end
        end
      end else begin
        st_nxt.part_bit_sum  = sum_fld;
        st_nxt.width_fault   = fault_fld;
        st_nxt.part_byte_pos = pos_inc;
        if (pos_inc >= st.part_bytes_needed) begin
          part_done = 1'b1;
        end else if (last) begin
          // truncation wins over a width fault already seen
          res_vld    = 1'b1;
          res.status = ST_HDR_TRUNC;
        end
      end

      if (part_done) begin
        priority if (c_fault) begin
          res_vld    = 1'b1;
          res.status = ST_WIDTH_BAD;
        end else if (run_tot > {1'b0, cap}) begin
          res_vld    = 1'b1;
          res.status = ST_PAY_TRUNC;
        end else if (cfg.walk_mode && st.parts_done == cfg.target_part) begin
          res_vld        = 1'b1;
          res.status     = ST_OK;
          res.hdr_offset = cons_inc - {11'd0, c_needed};
          res.bit_offset = st.running_bit_offset;
          res.bit_count  = {10'd0, c_sum};
          res.part_flags = c_flags;
        end else begin
          st_nxt.running_bit_offset = run_tot[18:0];
          st_nxt.parts_done         = parts_inc;
          st_nxt.awaiting_flags     = 1'b1;
          st_nxt.part_byte_pos      = 5'd0;
          st_nxt.part_bytes_needed  = 5'd0;
          st_nxt.part_bit_sum       = 9'd0;
          st_nxt.width_fault        = 1'b0;
          if (!cfg.walk_mode && parts_inc >= cfg.part_count) begin
            res_vld = 1'b1;
            if (last) begin
              res.status     = ST_OK;
              res.hdr_offset = cons_inc;
              res.bit_count  = run_tot[18:0];
            end else begin
              res.status = ST_TRAILING;
            end
          end else if (last) begin
            res_vld    = 1'b1;
            res.status = ST_HDR_TRUNC;
          end
        end
      end
    end

    // after a result the walk restarts at the end of the header
    if (res_vld) begin
      if (last) st_nxt = WALK_RESET;
      else st_nxt.stream_finished = 1'b1;
    end
  end

endmodule

/* design/anim_descriptor_layout_walker_unit.sv */
// Descriptor walker top level: header bytes go through an input register, the walk
// logic and a result register. One header byte is taken every clock cycle unless
// stalled. The only stall comes from the result register: while a result waits to
// be taken, a byte that would produce another result holds in the input register.
// The user writes registers through the apb port only while no byte is in flight;
// the block does not enforce this. Writes take effect at once.
`include "anim_descriptor_layout_walker_unit_assert.svh"
module anim_descriptor_layout_walker_unit (
  input  logic         clk,
  input  logic         rst_n,
  adlw_in_if.sink      in_ch,
  adlw_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import adlw_pkg::*;

  cfg_t        cfg;
  logic        stg_vld_r;
  logic [7:0]  stg_byte_r;
  logic        stg_last_r;
  walk_state_t st_r;
  walk_state_t st_nxt;
  logic        res_vld;
  result_t     res;
  logic        out_valid_r;
  result_t     out_r;
  logic        out_free;
  logic        proc_go;

  adlw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  adlw_step u_step (
    .st       (st_r),
    .cfg      (cfg),
    .hdr_byte (stg_byte_r),
    .last     (stg_last_r),
    .st_nxt   (st_nxt),
    .res_vld  (res_vld),
    .res      (res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  // bytes that produce no result pass even while the output is stalled
  assign proc_go     = stg_vld_r && (!res_vld || out_free);
  assign in_ch.ready = !stg_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_byte_r <= in_ch.header_byte;
      stg_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= WALK_RESET;
    end else if (proc_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_r.status;
  assign out_ch.hdr_offset = out_r.hdr_offset;
  assign out_ch.bit_offset = out_r.bit_offset;
  assign out_ch.bit_count  = out_r.bit_count;
  assign out_ch.part_flags = out_r.part_flags;

  `ADLW_ASSERT(a_pos_below_need, !st_r.awaiting_flags && !st_r.stream_finished |-> st_r.part_byte_pos < st_r.part_bytes_needed, "field position reached part length without completing")
  `ADLW_ASSERT(a_error_fields_zero, out_valid_r && out_r.status != ST_OK |-> out_r.hdr_offset == 16'd0 && out_r.bit_offset == 19'd0 && out_r.bit_count == 19'd0 && out_r.part_flags == 8'd0, "error result carries nonzero fields")
  `ADLW_ASSERT(a_result_from_byte, $rose(out_valid_r) |-> $past(proc_go), "result appeared without a processed byte")
  `ADLW_ASSERT_NEXT(a_finish_after_result, proc_go && res_vld && !stg_last_r, st_r.stream_finished, "walk did not skip to header end after a result")
  `ADLW_ASSERT_NEXT(a_restart_on_last, proc_go && res_vld && stg_last_r, st_r.awaiting_flags && st_r.bytes_consumed == 16'd0, "walk did not restart after final byte")

endmodule

/* tb/testbench.sv */
// self-checking testbench of the animation descriptor walker unit
`timescale 1ns / 1ps
module testbench;
  import adlw_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int SETTLE_CYCLES = 6;
  localparam int HDR_LIMIT     = 65535;

  typedef struct packed {
    logic [7:0] hb;
    logic       lst;
  } hdr_byte_t;

  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    hdr_byte_t   item;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  adlw_in_if  in_ch ();
  adlw_out_if out_ch ();

  anim_descriptor_layout_walker_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the registers
  bit locate_mode;
  int frame_cap_bytes;
  int parts_wanted;
  int target_idx;

  // walk state of the predictor
  bit         need_flags;
  bit         halted;
  bit         cur_fault;
  logic [7:0] cur_flags;
  int         cur_pos;
  int         cur_len;
  int         cur_bits;
  int         payload_bits;
  int         hdr_count;
  int         parts_walked;

  result_t  expected_results[$];
  dir_row_t directed_rows[$];

  int fail_count;
  int busy_items;
  int results_seen;
  int settings_written;
  int quiet_cycles;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_walk();
    need_flags   = 1'b1;
    halted       = 1'b0;
    cur_fault    = 1'b0;
    cur_flags    = 8'd0;
    cur_pos      = 0;
    cur_len      = 0;
    cur_bits     = 0;
    payload_bits = 0;
    hdr_count    = 0;
    parts_walked = 0;
  endfunction

  function automatic int translate_bytes(logic [7:0] f);
    if (f[FL_TRN08]) return int'(LEN_TRN08);
    if (f[FL_S16_TRN]) return int'(LEN_S16);
    if (f[FL_S32_TRN]) return int'(LEN_S32);
    return 0;
  endfunction

  function automatic int part_bytes(logic [7:0] f);
    return translate_bytes(f) + (f[FL_S16_ROT] ? int'(LEN_S16) : 0) +
           (f[FL_CAMERA] ? int'(LEN_CAM) : 0);
  endfunction

  // width ceiling of the field byte at pos, zero for a plain data byte
  function automatic int field_limit(logic [7:0] f, int pos);
    int tlen;
    int rel;
    tlen = translate_bytes(f);
    rel  = pos;
    if (rel < tlen) begin
      if (f[FL_S32_TRN]) return (rel % 5 == 0) ? int'(LIM_32) : 0;
      if (rel % 3 != 2) return 0;
      return f[FL_TRN08] ? int'(LIM_32) : int'(LIM_16);
    end
    rel = rel - tlen;
    if (f[FL_S16_ROT]) begin
      if (rel < int'(LEN_S16)) return (rel % 3 == 2) ? int'(LIM_16) : 0;
      rel = rel - int'(LEN_S16);
    end
    if (f[FL_CAMERA] && rel == 0) return int'(LIM_32);
    return 0;
  endfunction

  function automatic bit end_walk(logic [2:0] st, int db, int bo, int bc, logic [7:0] pf,
                                  bit lst, output result_t res);
    res.status     = st;
    res.hdr_offset = (db > 65535) ? 16'hFFFF : 16'(db);
    res.bit_offset = 19'(bo);
    res.bit_count  = 19'(bc);
    res.part_flags = pf;
    if (lst) clear_walk();
    else halted = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit close_part(bit lst, output result_t res);
    int cap;
    cap = ((frame_cap_bytes > HDR_LIMIT) ? HDR_LIMIT : frame_cap_bytes) * 8;
    if (cur_fault) return end_walk(ST_WIDTH_BAD, 0, 0, 0, 8'd0, lst, res);
    if (payload_bits + cur_bits > cap) return end_walk(ST_PAY_TRUNC, 0, 0, 0, 8'd0, lst, res);
    if (locate_mode && parts_walked == target_idx)
      return end_walk(ST_OK, hdr_count - cur_len, payload_bits, cur_bits, cur_flags, lst, res);
    payload_bits = payload_bits + cur_bits;
    if (parts_walked < 65535) parts_walked++;
    need_flags = 1'b1;
    cur_pos    = 0;
    cur_len    = 0;
    cur_bits   = 0;
    cur_fault  = 1'b0;
    if (!locate_mode && parts_walked >= parts_wanted) begin
      if (lst) return end_walk(ST_OK, hdr_count, 0, payload_bits, 8'd0, 1'b1, res);
      return end_walk(ST_TRAILING, 0, 0, 0, 8'd0, 1'b0, res);
    end
    if (lst) return end_walk(ST_HDR_TRUNC, 0, 0, 0, 8'd0, 1'b1, res);
    return 1'b0;
  endfunction

  // advances the walk by one header byte, returns 1 when it yields a result
  function automatic bit walk_byte(logic [7:0] b, bit lst, output result_t res);
    int modes;
    int lim;
    res = '0;
    if (halted) begin
      if (lst) clear_walk();
      return 1'b0;
    end
    if (hdr_count >= HDR_LIMIT) return end_walk(ST_HDR_TRUNC, 0, 0, 0, 8'd0, lst, res);
    hdr_count++;
    if (need_flags) begin
      if (!locate_mode && parts_walked >= parts_wanted)
        return end_walk(ST_TRAILING, 0, 0, 0, 8'd0, lst, res);
      modes = int'(b[FL_TRN08]) + int'(b[FL_S16_TRN]) + int'(b[FL_S32_TRN]);
      if (b[FL_UNKNOWN] || modes > 1 || (b[FL_S16_ROT] && b[FL_F32_ROT]))
        return end_walk(ST_BAD_FLAGS, 0, 0, 0, 8'd0, lst, res);
      cur_flags  = b;
      cur_pos    = 0;
      cur_len    = part_bytes(b);
      cur_bits   = (b[FL_F32_ROT] ? int'(F32_SPAN) : 0) + (b[FL_F32_SCL] ? int'(F32_SPAN) : 0);
      cur_fault  = 1'b0;
      need_flags = 1'b0;
      if (cur_len == 0) return close_part(lst, res);
    end else begin
      lim = field_limit(cur_flags, cur_pos);
      if (lim != 0) begin
        if (int'(b) > lim) cur_fault = 1'b1;
        else cur_bits = cur_bits + int'(b);
      end
      cur_pos++;
      if (cur_pos >= cur_len) return close_part(lst, res);
    end
    if (lst) return end_walk(ST_HDR_TRUNC, 0, 0, 0, 8'd0, 1'b1, res);
    return 1'b0;
  endfunction

  task automatic push_byte(hdr_byte_t it, bit typed, result_t want);
    result_t got;
    bit      has;
    bit      was_busy;
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.header_byte <= it.hb;
    in_ch.last_byte   <= it.lst;
    do @(posedge clk); while (!in_ch.ready);
    was_busy = !halted;
    has = walk_byte(it.hb, it.lst, got);
    if (was_busy) busy_items++;
    if (has) expected_results.push_back(typed ? want : got);
  endtask

  // sender holds off until every pending result is back, then lets the pipe settle
  task automatic hold_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    hold_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WALK_MODE:  locate_mode = v[0];
      REG_FRAME_LEN:  frame_cap_bytes = int'(v[15:0]);
      REG_PART_COUNT: parts_wanted = int'(v[15:0]);
      REG_TARGET:     target_idx = int'(v[15:0]);
      default: ;
    endcase
    settings_written++;
  endtask

  task automatic write_setting(bit m, int fl, int pc, int tg);
    write_reg(REG_WALK_MODE, 32'(m));
    write_reg(REG_FRAME_LEN, 32'(fl));
    write_reg(REG_PART_COUNT, 32'(pc));
    write_reg(REG_TARGET, 32'(tg));
  endtask

  // one descriptor: mostly well-formed parts, some bad flags, bad widths, cuts and extra bytes
  task automatic walk_descriptor();
    hdr_byte_t  q[$];
    result_t    none;
    int         n_parts;
    int         len;
    int         lim;
    int         cut;
    int         r;
    logic [7:0] f;
    logic [7:0] b;
    none = '0;
    if (locate_mode) begin
      n_parts = ((target_idx <= 6) ? target_idx + 1 : $urandom_range(1, 4)) + $urandom_range(0, 1);
    end else begin
      n_parts = (parts_wanted >= 1 && parts_wanted <= 6) ? parts_wanted : $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) n_parts = n_parts + ($urandom_range(0, 1) ? 1 : -1);
      if (n_parts < 1) n_parts = 1;
    end
    repeat (n_parts) begin
      if ($urandom_range(0, 9) == 0) begin
        f = 8'($urandom_range(0, 255));
      end else begin
        f = 8'd0;
        case ($urandom_range(0, 3))
          1: f[FL_S16_TRN] = 1'b1;
          2: f[FL_TRN08] = 1'b1;
          3: f[FL_S32_TRN] = 1'b1;
          default: ;
        endcase
        case ($urandom_range(0, 2))
          1: f[FL_S16_ROT] = 1'b1;
          2: f[FL_F32_ROT] = 1'b1;
          default: ;
        endcase
        f[FL_CAMERA]  = 1'($urandom_range(0, 1));
        f[FL_F32_SCL] = 1'($urandom_range(0, 1));
      end
      q.push_back({f, 1'b0});
      len = part_bytes(f);
      for (int pos = 0; pos < len; pos++) begin
        lim = field_limit(f, pos);
        r   = $urandom_range(0, 99);
        if (lim == 0) b = 8'($urandom_range(0, 255));
        else if (r < 15) b = 8'(lim);
        else if (r < 93) b = 8'($urandom_range(0, lim));
        else b = 8'($urandom_range(lim + 1, 255));
        q.push_back({b, 1'b0});
      end
    end
    q[q.size() - 1].lst = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      cut = $urandom_range(0, q.size() - 1);
      while (q.size() > cut + 1) void'(q.pop_back());
      q[cut].lst = 1'b1;
    end else if (r < 13) begin
      q[q.size() - 1].lst = 1'b0;
      repeat ($urandom_range(1, 3)) q.push_back({8'($urandom_range(0, 255)), 1'b0});
      q[q.size() - 1].lst = 1'b1;
    end
    foreach (q[i]) push_byte(q[i], 1'b0, none);
  endtask

  function automatic void row_byte(logic [7:0] b, bit lst);
    dir_row_t row;
    row        = '{default: '0};
    row.item   = {b, lst};
    directed_rows.push_back(row);
  endfunction

  function automatic void row_result(logic [7:0] b, bit lst, logic [2:0] st, int db, int bo,
                                     int bc, logic [7:0] pf);
    dir_row_t row;
    row        = '{default: '0};
    row.item   = {b, lst};
    row.typed  = 1'b1;
    row.want   = {st, 16'(db), 19'(bo), 19'(bc), pf};
    directed_rows.push_back(row);
  endfunction

  function automatic void row_reg(logic [1:0] idx, int v);
    dir_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.value   = 32'(v);
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("status: expected no transaction, got %0d", out_ch.status);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_ch.status));
        check_field("hdr_offset", 32'(want.hdr_offset), 32'(out_ch.hdr_offset));
        check_field("bit_offset", 32'(want.bit_offset), 32'(out_ch.bit_offset));
        check_field("bit_count", 32'(want.bit_count), 32'(out_ch.bit_count));
        check_field("part_flags", 32'(want.part_flags), 32'(out_ch.part_flags));
      end
    end
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
  end

  // nothing moving on either channel for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int        phase;
    int        items_start;
    int        fl;
    int        pc;
    int        tg;
    bit        m;
    in_ch.valid       = 1'b0;
    in_ch.header_byte = 8'd0;
    in_ch.last_byte   = 1'b0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = 4'd0;
    pwdata            = 32'd0;
    steady            = 1'b0;
    fail_count        = 0;
    busy_items        = 0;
    results_seen      = 0;
    settings_written  = 0;
    quiet_cycles      = 0;
    locate_mode       = 1'b0;
    frame_cap_bytes   = 0;
    parts_wanted      = 1;
    target_idx        = 0;
    clear_walk();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk from the reset settings: measure, no payload room, one part
    row_result(8'h80, 1'b1, ST_BAD_FLAGS, 0, 0, 0, 8'h00);
    row_result(8'h00, 1'b1, ST_OK, 1, 0, 0, 8'h00);
    row_result(8'h03, 1'b1, ST_HDR_TRUNC, 0, 0, 0, 8'h00);
    row_result(8'h06, 1'b1, ST_BAD_FLAGS, 0, 0, 0, 8'h00);
    row_result(8'h40, 1'b1, ST_PAY_TRUNC, 0, 0, 0, 8'h00);
    row_result(8'h09, 1'b0, ST_BAD_FLAGS, 0, 0, 0, 8'h00);
    row_byte(8'h7F, 1'b1);
    row_result(8'h00, 1'b0, ST_TRAILING, 0, 0, 0, 8'h00);
    row_byte(8'hFF, 1'b1);
    // camera width over its ceiling, reported on the last field byte
    row_byte(8'h20, 1'b0);
    row_byte(8'h21, 1'b0);
    row_byte(8'hFF, 1'b0);
    row_byte(8'hFF, 1'b0);
    row_byte(8'hFF, 1'b0);
    row_result(8'hFF, 1'b1, ST_WIDTH_BAD, 0, 0, 0, 8'h00);
    // early end of a part wins over a bad width
    row_byte(8'h10, 1'b0);
    row_byte(8'hFF, 1'b0);
    row_result(8'h00, 1'b1, ST_HDR_TRUNC, 0, 0, 0, 8'h00);
    row_reg(REG_PART_COUNT, 0);
    row_result(8'h00, 1'b1, ST_TRAILING, 0, 0, 0, 8'h00);
    row_reg(REG_FRAME_LEN, 65535);
    row_reg(REG_PART_COUNT, 2);
    row_byte(8'h08, 1'b0);
    row_byte(8'h48, 1'b1);
    row_reg(REG_WALK_MODE, 1);
    row_reg(REG_TARGET, 1);
    row_byte(8'h40, 1'b0);
    row_byte(8'h08, 1'b1);
    row_result(8'h40, 1'b1, ST_HDR_TRUNC, 0, 0, 0, 8'h00);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      else push_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    phase       = 0;
    items_start = busy_items;
    while (busy_items - items_start < RANDOM_ITEMS) begin
      case (phase)
        0: begin m = 1'b0; fl = 65535; pc = 1;     tg = 0;     end
        1: begin m = 1'b1; fl = 0;     pc = 65535; tg = 65534; end
        2: begin m = 1'b1; fl = 65535; pc = 2;     tg = 0;     end
        3: begin m = 1'b0; fl = 0;     pc = 3;     tg = 1;     end
        default: begin
          m  = 1'($urandom_range(0, 1));
          fl = $urandom_range(0, 99) < 30 ? $urandom_range(0, 60) :
               ($urandom_range(0, 99) < 65 ? 65535 : $urandom_range(0, 65535));
          pc = $urandom_range(0, 9) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 4);
          tg = $urandom_range(0, 19) == 0 ? 65534 : $urandom_range(0, 3);
        end
      endcase
      write_setting(m, fl, pc, tg);
      steady = (phase == 4);
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 99) < 15) hold_for_results();
        walk_descriptor();
      end
      steady = 1'b0;
      phase++;
    end

    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("walked %0d live header bytes, compared %0d results", busy_items, results_seen);
    $display("%0d register writes across measure and locate settings", settings_written);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
